// ===== rtl/pls_pkg.sv =====
// Shared widths, latencies and types of the Phong point-light shader.
package pls_pkg;
    localparam int IN_W       = 16;
    localparam int NCOMP_W    = 19;
    localparam int UNIT_W     = 17;
    localparam int SUMSQ_W    = 34;
    localparam int FRAC_W     = 14;
    localparam int NORM_SHIFT = 28;
    localparam int NORM_LAT   = 3 + (SUMSQ_W + NORM_SHIFT) / 2 + UNIT_W - 1;
    localparam int POW_W      = FRAC_W + 1;
    localparam int POW_LAT    = 8 * POW_W + 16;

    typedef logic signed [NCOMP_W-1:0] t_ncomp;
    typedef logic signed [UNIT_W-1:0]  t_unit;
endpackage

// ===== rtl/phong_point_light_shader.sv =====
// Top level of the Phong point-light shader pipeline.
//
//  Channel   Handshake                 Payload
//  command   i_start / o_busy          i_normal_*, i_view_*, i_frag_*, i_op
//  result    o_valid (strobe)          o_red, o_green, o_blue
//  config    i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One fragment is taken every cycle; o_busy is always low.
// Each taken beat passes through the chain of two normalizers, the power ladder of
// eight square-root units and the final divider. Synchronous reset clears the
// valid pipeline and config registers but sets r_shin and r_atten nonzero.
// The pipeline never stalls, since results cannot be held off.
module phong_point_light_shader (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic signed [15:0] i_normal_x,
    input  logic signed [15:0] i_normal_y,
    input  logic signed [15:0] i_normal_z,
    input  logic signed [15:0] i_view_x,
    input  logic signed [15:0] i_view_y,
    input  logic signed [15:0] i_view_z,
    input  logic signed [15:0] i_frag_x,
    input  logic signed [15:0] i_frag_y,
    input  logic signed [15:0] i_frag_z,
    input  logic               i_op,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [47:0]        i_cfg_data,
    output logic               o_valid,
    output logic [15:0]        o_red,
    output logic [15:0]        o_green,
    output logic [15:0]        o_blue
);
    localparam int CW  = pls_pkg::NCOMP_W;
    localparam int UW  = pls_pkg::UNIT_W;
    localparam int FW  = pls_pkg::POW_W;
    localparam int FR  = pls_pkg::FRAC_W;
    localparam int QW  = 16;
    localparam logic [FW-1:0] ONE = FW'(1) << FR;

    localparam int T_NN   = pls_pkg::NORM_LAT;
    localparam int T_C    = T_NN + 2;
    localparam int T_R    = T_C + 2;
    localparam int T_RN   = T_R + pls_pkg::NORM_LAT;
    localparam int T_BASE = T_RN + 2;
    localparam int T_SPEC = T_BASE + pls_pkg::POW_LAT;
    localparam int T_W    = T_SPEC + 2;
    localparam int T_CH   = T_W + 1;
    localparam int T_NUM  = T_CH + 1;
    localparam int T_Q    = T_NUM + QW;
    localparam int T_OUT  = T_Q + 1;
    localparam int DRW    = 25;
    localparam int T_D    = 3 + DRW;
    localparam int T_DEN  = T_D + 2;

    typedef enum logic [2:0] {
        REG_COLOR, REG_DIR, REG_POS, REG_AMB, REG_KD, REG_KS, REG_SHIN, REG_ATTEN
    } t_reg_idx;

    logic [47:0] r_color, r_dir, r_pos, r_atten;
    logic [15:0] r_amb, r_kd, r_ks, r_shin;
    logic [T_OUT:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color <= '0;
            r_dir   <= '0;
            r_pos   <= '0;
            r_amb   <= '0;
            r_kd    <= '0;
            r_ks    <= '0;
            r_shin  <= 16'h2000;
            r_atten <= 48'h0100_0000_0000;
            r_vld   <= '0;
        end else begin
            r_vld <= {r_vld[T_OUT-1:0], i_start};
            if (i_cfg_valid) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_COLOR: r_color <= i_cfg_data;
                    REG_DIR:   r_dir   <= i_cfg_data;
                    REG_POS:   r_pos   <= i_cfg_data;
                    REG_AMB:   r_amb   <= i_cfg_data[15:0];
                    REG_KD:    r_kd    <= i_cfg_data[15:0];
                    REG_KS:    r_ks    <= i_cfg_data[15:0];
                    REG_SHIN:  r_shin  <= i_cfg_data[15:0];
                    REG_ATTEN: r_atten <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_vld[T_OUT];

    logic signed [15:0] l_w [3];
    logic signed [15:0] pos_w [3];
    logic [15:0]        color_w [3];
    for (genvar i = 0; i < 3; i++) begin : g_lane
        assign l_w[i]     = r_dir[47-16*i -: 16];
        assign pos_w[i]   = r_pos[47-16*i -: 16];
        assign color_w[i] = r_color[47-16*i -: 16];
    end

    pls_pkg::t_ncomp    r_n [3];
    pls_pkg::t_ncomp    r_v [3];
    logic signed [15:0] r_frag [3];
    logic               r_op;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n[0]    <= CW'(i_normal_x);
            r_n[1]    <= CW'(i_normal_y);
            r_n[2]    <= CW'(i_normal_z);
            r_v[0]    <= CW'(i_view_x);
            r_v[1]    <= CW'(i_view_y);
            r_v[2]    <= CW'(i_view_z);
            r_frag[0] <= i_frag_x;
            r_frag[1] <= i_frag_y;
            r_frag[2] <= i_frag_z;
            r_op      <= i_op;
        end
    end

    pls_pkg::t_unit nn_w [3];
    pls_pkg::t_unit vn_w [3];

    pls_norm u_norm_n (.i_clk(i_clk), .i_v(r_n), .o_v(nn_w));
    pls_norm u_norm_v (.i_clk(i_clk), .i_v(r_v), .o_v(vn_w));

    // Diffuse term and the reflection vector.
    logic signed [32:0] r_p1 [3];
    logic signed [34:0] c_w;
    logic signed [34:0] r_c;
    logic [16:0]        r_diff;
    logic               r_cpos;

    assign c_w = r_p1[0] + r_p1[1] + r_p1[2];

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_p1[i] <= nn_w[i] * l_w[i];
        end
        r_c    <= c_w;
        r_cpos <= c_w > 0;
        r_diff <= (c_w > 0) ? 17'(c_w >>> FR) : '0;
    end

    logic [3*UW-1:0] nn_dp_w;
    pls_delay #(.W(3 * UW), .D(T_C - T_NN)) u_nn_dly (
        .i_clk (i_clk),
        .i_d   ({nn_w[0], nn_w[1], nn_w[2]}),
        .o_d   (nn_dp_w)
    );

    logic signed [51:0] r_m [3];
    pls_pkg::t_ncomp    r_r [3];

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_m[i] <= $signed(nn_dp_w[3*UW-1-UW*i -: UW]) * r_c;
            r_r[i] <= CW'((r_m[i] >>> (2 * FR - 1)) - l_w[i]);
        end
    end

    pls_pkg::t_unit rn_w [3];
    pls_norm u_norm_r (.i_clk(i_clk), .i_v(r_r), .o_v(rn_w));

    logic            cpos_d_w;
    logic [3*UW-1:0] vn_dp_w;

    pls_delay #(.W(1), .D(T_RN - T_C)) u_cpos_dly (
        .i_clk (i_clk),
        .i_d   (r_cpos),
        .o_d   (cpos_d_w)
    );

    pls_delay #(.W(3 * UW), .D(T_RN - T_NN)) u_vn_dly (
        .i_clk (i_clk),
        .i_d   ({vn_w[0], vn_w[1], vn_w[2]}),
        .o_d   (vn_dp_w)
    );

    // Specular base from the view and reflection vectors.
    logic signed [33:0] r_q1 [3];
    logic signed [35:0] vr_w;
    logic [FW-1:0]      r_base;

    assign vr_w = r_q1[0] + r_q1[1] + r_q1[2];

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_q1[i] <= (cpos_d_w ? rn_w[i] : UW'(0))
                       * $signed(vn_dp_w[3*UW-1-UW*i -: UW]);
        end
        if (vr_w > 0) begin
            if (vr_w[35:FR] > 22'(ONE)) begin
                r_base <= ONE;
            end else begin
                r_base <= vr_w[FR+FW-1:FR];
            end
        end else begin
            r_base <= '0;
        end
    end

    logic [FW-1:0] spec_w;
    pls_pow u_pow (.i_clk(i_clk), .i_base(r_base), .i_exp(r_shin), .o_pow(spec_w));

    logic [16:0] diff_d_w;
    pls_delay #(.W(17), .D(T_SPEC - T_C)) u_diff_dly (
        .i_clk (i_clk),
        .i_d   (r_diff),
        .o_d   (diff_d_w)
    );

    // Point-light distance and attenuation divisor.
    logic signed [16:0] r_dd [3];
    logic [16:0]        dmag_w [3];
    logic [33:0]        r_dsq [3];
    logic [33:0]        r_sq;
    logic [DRW-1:0]     d_w;
    logic [33:0]        sq_d_w;
    logic [40:0]        r_kld;
    logic [49:0]        r_kqs;
    logic [50:0]        r_den;
    logic [50:0]        den_d_w;

    for (genvar i = 0; i < 3; i++) begin : g_dmag
        assign dmag_w[i] = r_dd[i][16] ? 17'(-r_dd[i]) : 17'(r_dd[i]);
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_dd[i]  <= pos_w[i] - r_frag[i];
            r_dsq[i] <= dmag_w[i] * dmag_w[i];
        end
        r_sq  <= r_dsq[0] + r_dsq[1] + r_dsq[2];
        r_kld <= r_atten[31:16] * d_w;
        r_kqs <= r_atten[15:0] * sq_d_w;
        r_den <= {r_atten[47:32], 16'h0000} + r_kld + r_kqs;
    end

    pls_isqrt #(.IW(2 * DRW)) u_dist (
        .i_clk  (i_clk),
        .i_val  ({r_sq, 16'h0000}),
        .o_root (d_w)
    );

    pls_delay #(.W(34), .D(T_D - 3)) u_sq_dly (
        .i_clk (i_clk),
        .i_d   (r_sq),
        .o_d   (sq_d_w)
    );

    pls_delay #(.W(51), .D(T_CH - T_DEN)) u_den_dly (
        .i_clk (i_clk),
        .i_d   (r_den),
        .o_d   (den_d_w)
    );

    // Weight, channel products and the final divide.
    logic [32:0] r_wd;
    logic [30:0] r_ws;
    logic [33:0] r_weight;
    logic [49:0] r_ch [3];
    logic [51:0] r_num [3];
    logic [50:0] r_den2;
    logic [2:0]  r_ov;
    logic [15:0] r_dsat [3];

    always_ff @(posedge i_clk) begin
        r_wd     <= r_kd * diff_d_w;
        r_ws     <= r_ks * spec_w;
        r_weight <= {r_amb, 14'h0000} + r_wd + r_ws;
        r_den2   <= den_d_w;
        for (int i = 0; i < 3; i++) begin
            r_ch[i]  <= color_w[i] * r_weight;
            r_num[i] <= {r_ch[i], 2'b00};
            r_ov[i]  <= {r_ch[i], 2'b00} >= {den_d_w, 16'h0000};
            r_dsat[i] <= (|r_ch[i][49:38]) ? 16'hFFFF : r_ch[i][37:22];
        end
    end

    logic [QW-1:0] quo_w [3];
    for (genvar i = 0; i < 3; i++) begin : g_div
        pls_div #(.NW(52), .DW(51), .QW(QW)) u_div (
            .i_clk (i_clk),
            .i_num (r_num[i]),
            .i_den (r_den2),
            .o_quo (quo_w[i])
        );
    end

    logic [2:0]  ov_d_w;
    logic [47:0] dsat_d_w;
    logic        op_d_w;

    pls_delay #(.W(3), .D(T_Q - T_NUM)) u_ov_dly (
        .i_clk (i_clk),
        .i_d   (r_ov),
        .o_d   (ov_d_w)
    );

    pls_delay #(.W(48), .D(T_Q - T_NUM)) u_dsat_dly (
        .i_clk (i_clk),
        .i_d   ({r_dsat[0], r_dsat[1], r_dsat[2]}),
        .o_d   (dsat_d_w)
    );

    pls_delay #(.W(1), .D(T_Q)) u_op_dly (
        .i_clk (i_clk),
        .i_d   (r_op),
        .o_d   (op_d_w)
    );

    logic [15:0] res_w [3];
    for (genvar i = 0; i < 3; i++) begin : g_res
        assign res_w[i] = !op_d_w   ? dsat_d_w[47-16*i -: 16]
                        : ov_d_w[i] ? 16'hFFFF
                        :             quo_w[i];
    end

    always_ff @(posedge i_clk) begin
        o_red   <= res_w[0];
        o_green <= res_w[1];
        o_blue  <= res_w[2];
    end
endmodule

// ===== rtl/pls_delay.sv =====
// Fixed-length register delay line.
module pls_delay #(
    parameter int W = 1,
    parameter int D = 1
) (
    input  logic         i_clk,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_d
);
    if (D == 0) begin : g_pass
        assign o_d = i_d;
    end else begin : g_line
        logic [W-1:0] r_sh [D];
        always_ff @(posedge i_clk) begin
            r_sh[0] <= i_d;
            for (int k = 1; k < D; k++) begin
                r_sh[k] <= r_sh[k-1];
            end
        end
        assign o_d = r_sh[D-1];
    end
endmodule

// ===== rtl/pls_isqrt.sv =====
// Pipelined integer square root, one root bit per stage.
module pls_isqrt #(
    parameter int IW = 62
) (
    input  logic            i_clk,
    input  logic [IW-1:0]   i_val,
    output logic [IW/2-1:0] o_root
);
    localparam int RW  = IW / 2;
    localparam int RMW = RW + 2;

    logic [IW-1:0]  r_x   [RW];
    logic [RMW-1:0] r_rem [RW];
    logic [RW-1:0]  r_q   [RW];

    for (genvar k = 0; k < RW; k++) begin : g_step
        logic [IW-1:0]  x_in;
        logic [RMW-1:0] rem_in;
        logic [RW-1:0]  q_in;
        logic [RMW+1:0] rem_sh;
        logic [RMW+1:0] trial;
        if (k == 0) begin : g_head
            assign x_in   = i_val;
            assign rem_in = '0;
            assign q_in   = '0;
        end else begin : g_body
            assign x_in   = r_x[k-1];
            assign rem_in = r_rem[k-1];
            assign q_in   = r_q[k-1];
        end
        assign rem_sh = {rem_in, x_in[IW-1:IW-2]};
        assign trial  = {2'b00, q_in, 2'b01};
        always_ff @(posedge i_clk) begin
            r_x[k] <= {x_in[IW-3:0], 2'b00};
            if (rem_sh >= trial) begin
                r_rem[k] <= RMW'(rem_sh - trial);
                r_q[k]   <= {q_in[RW-2:0], 1'b1};
            end else begin
                r_rem[k] <= RMW'(rem_sh);
                r_q[k]   <= {q_in[RW-2:0], 1'b0};
            end
        end
    end

    assign o_root = r_q[RW-1];
endmodule

// ===== rtl/pls_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module pls_div #(
    parameter int NW = 47,
    parameter int DW = 31,
    parameter int QW = 16
) (
    input  logic          i_clk,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quo
);
    localparam int CW = (NW > DW + QW) ? NW : DW + QW;

    logic [NW-1:0] r_num [QW];
    logic [DW-1:0] r_den [QW];
    logic [QW-1:0] r_quo [QW];

    for (genvar k = 0; k < QW; k++) begin : g_step
        localparam int B = QW - 1 - k;
        logic [NW-1:0] num_in;
        logic [DW-1:0] den_in;
        logic [QW-1:0] quo_in;
        logic [CW-1:0] rem_w;
        logic [CW-1:0] dsh_w;
        if (k == 0) begin : g_head
            assign num_in = i_num;
            assign den_in = i_den;
            assign quo_in = '0;
        end else begin : g_body
            assign num_in = r_num[k-1];
            assign den_in = r_den[k-1];
            assign quo_in = r_quo[k-1];
        end
        assign rem_w = CW'(num_in);
        assign dsh_w = CW'(den_in) << B;
        always_ff @(posedge i_clk) begin
            r_den[k] <= den_in;
            if (rem_w >= dsh_w) begin
                r_num[k] <= NW'(rem_w - dsh_w);
                r_quo[k] <= quo_in | (QW'(1) << B);
            end else begin
                r_num[k] <= num_in;
                r_quo[k] <= quo_in;
            end
        end
    end

    assign o_quo = r_quo[QW-1];
endmodule

// ===== rtl/pls_norm.sv =====
// Vector normalizer: sum of squares, square root and three component divides.
module pls_norm (
    input  logic            i_clk,
    input  pls_pkg::t_ncomp i_v [3],
    output pls_pkg::t_unit  o_v [3]
);
    localparam int CW   = pls_pkg::NCOMP_W;
    localparam int SW   = pls_pkg::SUMSQ_W;
    localparam int SH   = pls_pkg::NORM_SHIFT;
    localparam int LW   = (SW + SH) / 2;
    localparam int NUMW = CW + SH;
    localparam int UW   = pls_pkg::UNIT_W;
    localparam int QW   = UW - 1;

    logic [CW-1:0]   mag_w [3];
    logic [CW-1:0]   r_mag [3];
    logic [2:0]      r_neg;
    logic [2*CW-1:0] r_sq  [3];
    logic [SW-1:0]   r_s;
    logic [LW-1:0]   len_w;
    logic [3*CW-1:0] mag_d_w;
    logic [2:0]      neg_d_w;
    logic            zero_d_w;
    logic [QW-1:0]   quo_w [3];
    pls_pkg::t_unit  r_out [3];

    for (genvar i = 0; i < 3; i++) begin : g_mag
        assign mag_w[i] = i_v[i][CW-1] ? CW'(-i_v[i]) : CW'(i_v[i]);
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_mag[i] <= mag_w[i];
            r_neg[i] <= i_v[i][CW-1];
            r_sq[i]  <= mag_w[i] * mag_w[i];
        end
        r_s <= SW'(r_sq[0] + r_sq[1] + r_sq[2]);
    end

    pls_isqrt #(.IW(SW + SH)) u_len (
        .i_clk  (i_clk),
        .i_val  ({r_s, {SH{1'b0}}}),
        .o_root (len_w)
    );

    pls_delay #(.W(3 * CW), .D(LW + 1)) u_mag_dly (
        .i_clk (i_clk),
        .i_d   ({r_mag[0], r_mag[1], r_mag[2]}),
        .o_d   (mag_d_w)
    );

    pls_delay #(.W(3), .D(LW + QW + 1)) u_neg_dly (
        .i_clk (i_clk),
        .i_d   (r_neg),
        .o_d   (neg_d_w)
    );

    pls_delay #(.W(1), .D(LW + QW)) u_zero_dly (
        .i_clk (i_clk),
        .i_d   (r_s == '0),
        .o_d   (zero_d_w)
    );

    for (genvar i = 0; i < 3; i++) begin : g_div
        pls_div #(.NW(NUMW), .DW(LW), .QW(QW)) u_div (
            .i_clk (i_clk),
            .i_num ({mag_d_w[3*CW-1-CW*i -: CW], {SH{1'b0}}}),
            .i_den (len_w),
            .o_quo (quo_w[i])
        );
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            if (zero_d_w) begin
                r_out[i] <= '0;
            end else if (neg_d_w[i]) begin
                r_out[i] <= -UW'(quo_w[i]);
            end else begin
                r_out[i] <= UW'(quo_w[i]);
            end
        end
    end

    assign o_v = r_out;
endmodule

// ===== rtl/pls_pow.sv =====
// Fixed-point power: square and square-root ladder, then bitwise exponent products.
module pls_pow (
    input  logic                        i_clk,
    input  logic [pls_pkg::POW_W-1:0]   i_base,
    input  logic [15:0]                 i_exp,
    output logic [pls_pkg::POW_W-1:0]   o_pow
);
    localparam int FW = pls_pkg::POW_W;
    localparam int FR = pls_pkg::FRAC_W;
    localparam logic [FW-1:0] ONE = FW'(1) << FR;

    logic [FW-1:0] r_sq  [7];
    wire  [FW-1:0] f_w   [16];
    wire  [FW-1:0] fd_w  [16];
    logic [FW-1:0] r_acc [16];

    assign f_w[8] = i_base;

    for (genvar j = 0; j < 7; j++) begin : g_sq
        logic [FW-1:0]   sq_in;
        logic [2*FW-1:0] prod;
        if (j == 0) begin : g_head
            assign sq_in = i_base;
        end else begin : g_body
            assign sq_in = r_sq[j-1];
        end
        assign prod = sq_in * sq_in;
        always_ff @(posedge i_clk) begin
            r_sq[j] <= prod[FR+FW-1:FR];
        end
        assign f_w[9+j] = r_sq[j];
    end

    for (genvar j = 0; j < 8; j++) begin : g_rt
        pls_isqrt #(.IW(2 * FW)) u_rt (
            .i_clk  (i_clk),
            .i_val  ({1'b0, f_w[8-j], {FR{1'b0}}}),
            .o_root (f_w[7-j])
        );
    end

    for (genvar k = 0; k < 16; k++) begin : g_acc
        localparam int D = (k < 8) ? k * (FW + 1) : 8 * FW + 8;
        logic [FW-1:0]   acc_in;
        logic [2*FW-1:0] prod;
        pls_delay #(.W(FW), .D(D)) u_fdly (
            .i_clk (i_clk),
            .i_d   (f_w[k]),
            .o_d   (fd_w[k])
        );
        if (k == 0) begin : g_head
            assign acc_in = ONE;
        end else begin : g_body
            assign acc_in = r_acc[k-1];
        end
        assign prod = acc_in * fd_w[k];
        always_ff @(posedge i_clk) begin
            r_acc[k] <= i_exp[k] ? prod[FR+FW-1:FR] : acc_in;
        end
    end

    assign o_pow = r_acc[15];
endmodule
